[src/wdagg_pkg.sv]
// ----------------------------------------------------------------------------
// wdagg_pkg
// Shared types and constants of the multi-client watchdog aggregator.
// ----------------------------------------------------------------------------
package wdagg_pkg;

    // Field widths fixed by the item format
    localparam int CLIENT_W    = 4;
    localparam int LIMIT_W     = 32;
    localparam int MASK_W      = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = MASK_W;

    // Highest client index the item format can address, plus one
    localparam int MAX_CLIENTS = 1 << CLIENT_W;

    // Commands
    typedef enum logic [1:0] {
        CMD_KICK        = 2'd0,
        CMD_KICK_CHECK  = 2'd1,
        CMD_KICK_EXTEND = 2'd2,
        CMD_TICK        = 2'd3
    } cmd_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WDOG_ENABLE = 1'd1;

endpackage

[src/wdagg_if.sv]
// ----------------------------------------------------------------------------
// wdagg_if
// Valid/ready channels: command items in, result items out.
// ----------------------------------------------------------------------------
interface wdagg_req_if
    import wdagg_pkg::*;
;
    logic                valid;
    logic                ready;
    cmd_t                command;
    logic [CLIENT_W-1:0] client;
    logic [LIMIT_W-1:0]  tick_limit;

    modport source (output valid, command, client, tick_limit, input ready);
    modport sink   (input valid, command, client, tick_limit, output ready);
endinterface

interface wdagg_rsp_if;
    logic valid;
    logic ready;
    logic reload;
    logic all_marked;

    modport source (output valid, reload, all_marked, input ready);
    modport sink   (input valid, reload, all_marked, output ready);
endinterface

[src/multi_client_watchdog_aggregator.sv]
// ----------------------------------------------------------------------------
// multi_client_watchdog_aggregator
// Collects kicks from several clients and reloads one hardware watchdog
// when an enabled kick-check finds every registered client marked.
// ----------------------------------------------------------------------------
//  channel | dir | fields                          | transfer
//  --------+-----+---------------------------------+------------------------
//  req     | in  | command, client, tick_limit     | valid && ready
//  rsp     | out | reload, all_marked              | valid && ready
//  cfg     | in  | cfg_index, cfg_wdata            | cfg_we
//
//  One item per cycle sustained while results are taken; an item waits in the
//  input register and its result is then captured in the result register.
//  Marks and counter update in the same cycle the result is formed.
//  Reset clears marks, counters and configuration; no clearing pass.
//  A stalled result holds the input register; req.ready drops only then.
// ----------------------------------------------------------------------------
module multi_client_watchdog_aggregator
    import wdagg_pkg::*;
#(
    parameter int NUM_CLIENTS = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    wdagg_req_if.sink             req,
    wdagg_rsp_if.source           rsp
);

    // Only clients the item format can address get storage
    localparam int NUM_SLOTS = (NUM_CLIENTS < MAX_CLIENTS) ? NUM_CLIENTS : MAX_CLIENTS;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Configuration
    logic [MASK_W-1:0] client_mask_reg;
    logic              wdog_enable_reg;

    // Input register
    logic                s1_valid_reg;
    cmd_t                s1_command_reg;
    logic [CLIENT_W-1:0] s1_client_reg;
    logic [LIMIT_W-1:0]  s1_limit_reg;

    // Result register
    logic rsp_valid_reg;
    logic rsp_reload_reg;
    logic rsp_all_marked_reg;

    // Client state
    logic [NUM_SLOTS-1:0]   marks_reg;
    logic [NUM_SLOTS-1:0]   marks_next;
    logic [COUNT_WIDTH-1:0] count_reg  [NUM_SLOTS];
    logic [COUNT_WIDTH-1:0] count_next [NUM_SLOTS];

    logic                   advance;
    logic                   process;
    logic                   in_range;
    logic [IDX_W-1:0]       idx;
    logic [NUM_SLOTS-1:0]   caller_sel;
    logic [NUM_SLOTS-1:0]   need;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic                   check_pass;
    logic                   reload_next;
    logic                   all_marked_next;

    // Handshake
    assign advance    = !rsp_valid_reg || rsp.ready;
    assign process    = s1_valid_reg && advance;
    assign req.ready  = !s1_valid_reg || advance;

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.reload     = rsp_reload_reg;
    assign rsp.all_marked = rsp_all_marked_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            client_mask_reg <= '0;
            wdog_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CLIENT_MASK: client_mask_reg <= cfg_wdata;
                CFG_WDOG_ENABLE: wdog_enable_reg <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req.ready)
            s1_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_command_reg <= req.command;
            s1_client_reg  <= req.client;
            s1_limit_reg   <= req.tick_limit;
        end
    end

    // Decode caller
    assign in_range  = 32'(s1_client_reg) < NUM_CLIENTS;
    assign idx       = IDX_W'(s1_client_reg);
    assign cur_count = count_reg[idx];
    assign need      = client_mask_reg[NUM_SLOTS-1:0];

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
            caller_sel[i] = (s1_client_reg == CLIENT_W'(i));
    end

    // Check sees the caller already marked
    assign check_pass = &((marks_reg | caller_sel) | ~need);

    // Command execution
    always_comb
    begin
        marks_next      = marks_reg;
        count_next      = count_reg;
        reload_next     = 1'b0;
        all_marked_next = 1'b0;
        if (process && in_range)
        begin
            case (s1_command_reg)
                CMD_KICK:
                    marks_next = marks_reg | caller_sel;
                CMD_KICK_CHECK:
                begin
                    marks_next = marks_reg | caller_sel;
                    if (wdog_enable_reg && check_pass)
                    begin
                        all_marked_next = 1'b1;
                        reload_next     = 1'b1;
                        marks_next      = '0;
                    end
                end
                CMD_KICK_EXTEND:
                begin
                    marks_next      = marks_reg | caller_sel;
                    count_next[idx] = '0;
                end
                CMD_TICK:
                begin
                    if (32'(cur_count) < s1_limit_reg)
                        marks_next = marks_reg | caller_sel;
                    if (cur_count != '1)
                        count_next[idx] = cur_count + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Client state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
                count_reg[i] <= '0;
        end
        else
        begin
            marks_reg <= marks_next;
            count_reg <= count_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (advance)
            rsp_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            rsp_reload_reg     <= reload_next;
            rsp_all_marked_reg <= all_marked_next;
        end
    end

    // Assertions
    a_reload_implies_marked: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (!rsp_reload_reg || rsp_all_marked_reg))
        else $error("reload without all clients marked");

    a_reload_clears_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (process && reload_next) |=> (marks_reg == '0))
        else $error("marks not cleared after reload");

    a_disabled_no_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (process && !wdog_enable_reg) |=> (rsp_valid_reg && !rsp_reload_reg))
        else $error("reload while watchdog disabled");

endmodule
